// ===== hdl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last_of_item;
	} result_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'd0,
		MODE_ESCAPE = 4'd1,
		MODE_HEX1   = 4'd2,
		MODE_SLASH2 = 4'd3,
		MODE_U2     = 4'd4,
		MODE_HEX2   = 4'd5
	} mode_t;

	typedef enum logic [1:0] {
		OP_RAW = 2'd0,
		OP_CP  = 2'd1,
		OP_END = 2'd2,
		OP_ERR = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [20:0] cp;
	} cmd_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;

	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;

	localparam logic [7:0] UTF_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF_LEAD3 = 8'he0;
	localparam logic [7:0] UTF_LEAD4 = 8'hf0;
	localparam logic [7:0] UTF_CONT  = 8'h80;

	// bit 4: digit is valid, bits 3:0: its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		hex_digit = 5'h00;
		case (c) inside
			[8'h30:8'h39]: begin
				t = c - 8'h30;
				hex_digit = {1'b1, t[3:0]};
			end
			[8'h61:8'h66]: begin
				t = c - 8'h57;
				hex_digit = {1'b1, t[3:0]};
			end
			[8'h41:8'h46]: begin
				t = c - 8'h37;
				hex_digit = {1'b1, t[3:0]};
			end
			default: hex_digit = 5'h00;
		endcase
	endfunction

	// bit 8: known single-byte escape, bits 7:0: the byte
	function automatic logic [8:0] esc_byte(input logic [7:0] c);
		case (c)
			CH_R:      esc_byte = {1'b1, 8'h0d};
			CH_N:      esc_byte = {1'b1, 8'h0a};
			CH_QUOTE:  esc_byte = {1'b1, CH_QUOTE};
			CH_SLASH:  esc_byte = {1'b1, CH_SLASH};
			CH_B:      esc_byte = {1'b1, 8'h08};
			CH_T:      esc_byte = {1'b1, 8'h09};
			CH_F:      esc_byte = {1'b1, 8'h0c};
			CH_BSLASH: esc_byte = {1'b1, CH_BSLASH};
			default:   esc_byte = 9'h000;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== hdl/jsu_front.sv =====
`default_nettype none
module jsu_front import jsu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire item_t item,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	mode_t       mode_q, mode_d;
	logic [1:0]  hc_q, hc_d;
	logic [15:0] first_q, first_d;
	logic [15:0] second_q, second_d;

	logic [4:0]  hx;
	logic [8:0]  esc;
	logic [15:0] first_sh;
	logic [15:0] second_sh;
	logic [20:0] pair_cp;
	logic [7:0]  c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			hc_q     <= 2'd0;
			first_q  <= 16'h0000;
			second_q <= 16'h0000;
		end else if (accept) begin
			mode_q   <= mode_d;
			hc_q     <= hc_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		c         = item.in_byte;
		hx        = hex_digit(c);
		esc       = esc_byte(c);
		first_sh  = {first_q[11:0], hx[3:0]};
		second_sh = {second_q[11:0], hx[3:0]};
		pair_cp   = 21'h010000 + {1'b0, first_q[9:0], second_sh[9:0]};

		mode_d    = mode_q;
		hc_d      = hc_q;
		first_d   = first_q;
		second_d  = second_q;
		cmd_valid = 1'b0;
		cmd.op    = OP_RAW;
		cmd.cp    = {13'h0000, c};

		if (item.stream_end) begin
			cmd_valid = 1'b1;
			cmd.op    = OP_ERR;
		end else begin
			case (mode_q)
				MODE_ESCAPE: begin
					mode_d = MODE_NORMAL;
					if (esc[8]) begin
						cmd_valid = 1'b1;
						cmd.cp    = {13'h0000, esc[7:0]};
					end else if (c == CH_U) begin
						mode_d  = MODE_HEX1;
						hc_d    = 2'd0;
						first_d = 16'h0000;
					end else begin
						cmd_valid = 1'b1;
						cmd.op    = OP_ERR;
					end
				end
				MODE_HEX1: begin
					if (!hx[4]) begin
						cmd_valid = 1'b1;
						cmd.op    = OP_ERR;
					end else begin
						first_d = first_sh;
						if (hc_q != 2'd3) begin
							hc_d = hc_q + 2'd1;
						end else begin
							hc_d = 2'd0;
							if (first_sh[15:10] == SURR_HIGH) begin
								mode_d = MODE_SLASH2;
							end else begin
								cmd_valid = 1'b1;
								cmd.op    = OP_CP;
								cmd.cp    = {5'h00, first_sh};
							end
						end
					end
				end
				MODE_SLASH2: begin
					if (c == CH_BSLASH) begin
						mode_d = MODE_U2;
					end else begin
						cmd_valid = 1'b1;
						cmd.op    = OP_ERR;
					end
				end
				MODE_U2: begin
					if (c == CH_U) begin
						mode_d   = MODE_HEX2;
						hc_d     = 2'd0;
						second_d = 16'h0000;
					end else begin
						cmd_valid = 1'b1;
						cmd.op    = OP_ERR;
					end
				end
				MODE_HEX2: begin
					if (!hx[4]) begin
						cmd_valid = 1'b1;
						cmd.op    = OP_ERR;
					end else begin
						second_d = second_sh;
						if (hc_q != 2'd3) begin
							hc_d = hc_q + 2'd1;
						end else if (second_sh[15:10] != SURR_LOW) begin
							cmd_valid = 1'b1;
							cmd.op    = OP_ERR;
						end else begin
							cmd_valid = 1'b1;
							cmd.op    = OP_CP;
							cmd.cp    = pair_cp;
						end
					end
				end
				default: begin
					mode_d = MODE_NORMAL;
					if (c == CH_QUOTE) begin
						cmd_valid = 1'b1;
						cmd.op    = OP_END;
					end else if (c == CH_BSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						cmd_valid = 1'b1;
					end
				end
			endcase
		end

		// any result other than a raw byte (a code point, the end or an error) returns to the initial state
		if (cmd_valid && cmd.op != OP_RAW) begin
			mode_d   = MODE_NORMAL;
			hc_d     = 2'd0;
			first_d  = 16'h0000;
			second_d = 16'h0000;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/jsu_cmdq.sv =====
`default_nettype none
module jsu_cmdq import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      rd_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign full     = (cnt_q == DEPTH_C);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== hdl/jsu_back.sv =====
`default_nettype none
module jsu_back import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_take,
	output result_t   result,
	output logic      empty,
	input  wire logic pop
);

	logic [1:0] idx_q;
	logic       out_v_q;
	result_t    out_q;

	logic       load;
	logic [1:0] last_idx;
	logic [7:0] b0, b1, b2, b3;
	logic [7:0] sel;
	logic [1:0] kind;
	logic [20:0] cp;

	always_comb begin
		cp       = cmd.cp;
		b0       = cp[7:0];
		b1       = 8'h00;
		b2       = 8'h00;
		b3       = 8'h00;
		last_idx = 2'd0;
		kind     = KIND_BYTE;
		case (cmd.op)
			OP_CP: begin
				if (cp[20:7] == 14'h0000) begin
					b0 = cp[7:0];
				end else if (cp[20:11] == 10'h000) begin
					b0       = UTF_LEAD2 | {3'b000, cp[10:6]};
					b1       = UTF_CONT | {2'b00, cp[5:0]};
					last_idx = 2'd1;
				end else if (cp[20:16] == 5'h00) begin
					b0       = UTF_LEAD3 | {4'h0, cp[15:12]};
					b1       = UTF_CONT | {2'b00, cp[11:6]};
					b2       = UTF_CONT | {2'b00, cp[5:0]};
					last_idx = 2'd2;
				end else begin
					b0       = UTF_LEAD4 | {5'h00, cp[20:18]};
					b1       = UTF_CONT | {2'b00, cp[17:12]};
					b2       = UTF_CONT | {2'b00, cp[11:6]};
					b3       = UTF_CONT | {2'b00, cp[5:0]};
					last_idx = 2'd3;
				end
			end
			OP_END: begin
				b0   = 8'h00;
				kind = KIND_END;
			end
			OP_ERR: begin
				b0   = 8'h00;
				kind = KIND_ERROR;
			end
			default: b0 = cp[7:0];
		endcase

		case (idx_q)
			2'd0:    sel = b0;
			2'd1:    sel = b1;
			2'd2:    sel = b2;
			default: sel = b3;
		endcase

		load     = cmd_valid && (!out_v_q || pop);
		cmd_take = load && (idx_q == last_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= cmd_take ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte     <= sel;
			out_q.kind         <= kind;
			out_q.last_of_item <= (idx_q == last_idx);
		end
	end

	assign result = out_q;
	assign empty  = !out_v_q;

endmodule
`default_nettype wire

// ===== hdl/json_string_unescape_utf8.sv =====
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------
// input    | push / full        | item   : in_byte, stream_end
// output   | empty / pop        | result : out_byte, kind, last_of_item
//
// Input bytes are parsed at one per cycle while the queue is not full; the parser
// posts at most one command per byte into a QDEPTH-entry command queue. The
// expander drains one result byte per cycle unless the output stalls; a command
// gives 1 to 4 bytes (UTF-8 length); full rises only when the queue fills behind
// a long output stall. arst_n clears parser state, queue pointers and the output valid flag.
`default_nettype none
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);

	logic accept;
	logic f_valid;
	cmd_t f_cmd;
	logic q_valid;
	cmd_t q_cmd;
	logic q_take;

	assign accept = push && !full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cmd_valid (f_valid),
		.cmd       (f_cmd)
	);

	jsu_cmdq #(.DEPTH(QDEPTH)) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && f_valid),
		.wr_data  (f_cmd),
		.full     (full),
		.rd_en    (q_take),
		.rd_data  (q_cmd),
		.rd_valid (q_valid)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_take  (q_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire

// ===== hdl/jsu_check.sv =====
`default_nettype none
module jsu_check import jsu_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    push,
	input wire logic    full,
	input wire item_t   item,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed before transfer");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.kind == KIND_BYTE || result.kind == KIND_END ||
			result.kind == KIND_ERROR))
		else $error("undefined result kind");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_BYTE) |->
			(result.last_of_item && result.out_byte == 8'h00))
		else $error("status result not alone or carries a byte");

	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last_of_item) |->
			(result.kind == KIND_BYTE && result.out_byte[7] == 1'b1))
		else $error("multi-byte result holds a plain byte");

endmodule

bind json_string_unescape_utf8 jsu_check u_check (.*);
`default_nettype wire
